[rtl/apc_pkg.sv]
// Shared types, constants and step functions for the accelerometer pose classifier.
`timescale 1ns / 1ps

package apc_pkg;

	localparam int NUM_REFS  = 4;
	localparam int REG_IDX_W = 3;

	localparam logic [REG_IDX_W-1:0] REG_CALIBRATED  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_REF_UPRIGHT = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_REF_LEFT    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_REF_RIGHT   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_REF_FLAT    = 3'd4;

	typedef enum logic [2:0] {
		POSE_UNKNOWN = 3'd0,
		POSE_UPRIGHT = 3'd1,
		POSE_LEFT    = 3'd2,
		POSE_RIGHT   = 3'd3,
		POSE_FLAT    = 3'd4
	} pose_t;

	// square root: 64-bit radicand, 32-bit root, two root bits per stage
	localparam int RAD_W     = 64;
	localparam int ROOT_W    = 32;
	localparam int REM_W     = ROOT_W + 2;
	localparam int SQ_PER    = 2;
	localparam int SQ_STAGES = ROOT_W / SQ_PER;

	// cosine divider: 16 fraction bits, quotient stays below 2^18
	localparam int DEN_W      = 64;
	localparam int COS_FRAC   = 16;
	localparam int QW         = COS_FRAC + 2;
	localparam int DIV_PER    = 2;
	localparam int DIV_STAGES = QW / DIV_PER;

	localparam logic [QW-1:0] COS_MIN = QW'(1) << (COS_FRAC - 1);

	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sq_acc_t;

	typedef struct packed {
		sq_acc_t          acc;
		logic [RAD_W-1:0] rad;
	} sq_pipe_t;

	typedef struct packed {
		logic [DEN_W-1:0] rem;
		logic [QW-1:0]    q;
	} dv_acc_t;

	typedef struct packed {
		dv_acc_t          acc;
		logic [QW-1:0]    low;
		logic [DEN_W-1:0] den;
	} dv_pipe_t;

	typedef struct packed {
		logic                vld;
		pose_t               fpose;
		logic [NUM_REFS-1:0] use_ref;
	} ctl_t;

	// one digit of the restoring square root
	function automatic sq_acc_t sq_step(sq_acc_t a, logic [1:0] pair);
		logic [REM_W+1:0] r;
		logic [REM_W+1:0] t;
		sq_acc_t o;
		r = {a.rem, pair};
		t = (REM_W + 2)'({a.root, 2'b01});
		if (r >= t) begin
			o.rem  = REM_W'(r - t);
			o.root = {a.root[ROOT_W-2:0], 1'b1};
		end else begin
			o.rem  = REM_W'(r);
			o.root = {a.root[ROOT_W-2:0], 1'b0};
		end
		return o;
	endfunction

	// one bit of the restoring divider
	function automatic dv_acc_t dv_step(dv_acc_t a, logic [DEN_W-1:0] den, logic nbit);
		logic [DEN_W:0] r;
		dv_acc_t o;
		r = {a.rem, nbit};
		if (r >= {1'b0, den}) begin
			o.rem = DEN_W'(r - {1'b0, den});
			o.q   = {a.q[QW-2:0], 1'b1};
		end else begin
			o.rem = r[DEN_W-1:0];
			o.q   = {a.q[QW-2:0], 1'b0};
		end
		return o;
	endfunction

endpackage

[rtl/apc_dot3.sv]
// Registered three-term signed dot product, two stages.
`timescale 1ns / 1ps

module apc_dot3 #(
	parameter int W = 16
) (
	input  logic                clk,
	input  logic signed [W-1:0] a [3],
	input  logic signed [W-1:0] b [3],
	output logic signed [2*W:0] dot
);

	logic signed [2*W-1:0] prod_s1 [3];

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			prod_s1[k] <= a[k] * b[k];
		end
		dot <= (2*W+1)'(prod_s1[0]) + (2*W+1)'(prod_s1[1]) + (2*W+1)'(prod_s1[2]);
	end

endmodule

[rtl/apc_isqrt.sv]
// Pipelined integer square root, a fixed number of root bits per stage.
`timescale 1ns / 1ps

module apc_isqrt
	import apc_pkg::*;
(
	input  logic              clk,
	input  logic [RAD_W-1:0]  rad,
	output logic [ROOT_W-1:0] root
);

	sq_pipe_t stg_s [SQ_STAGES];
	sq_pipe_t head;

	assign head = '{acc: '{rem: '0, root: '0}, rad: rad};

	for (genvar k = 0; k < SQ_STAGES; k++) begin : g_stage
		sq_pipe_t prev;
		sq_pipe_t nxt;

		if (k == 0) begin : g_first
			assign prev = head;
		end else begin : g_next
			assign prev = stg_s[k-1];
		end

		always_comb begin
			nxt = prev;
			for (int j = 0; j < SQ_PER; j++) begin
				nxt.acc = sq_step(nxt.acc, nxt.rad[RAD_W-1 -: 2]);
				nxt.rad = {nxt.rad[RAD_W-3:0], 2'b00};
			end
		end

		always_ff @(posedge clk) begin
			stg_s[k] <= nxt;
		end
	end

	assign root = stg_s[SQ_STAGES-1].acc.root;

endmodule

[rtl/apc_cosdiv.sv]
// Cosine quotient: norm product, then a pipelined restoring divider.
`timescale 1ns / 1ps

module apc_cosdiv
	import apc_pkg::*;
(
	input  logic              clk,
	input  logic [DEN_W-1:0]  num,
	input  logic [ROOT_W-1:0] na,
	input  logic [ROOT_W-1:0] nb,
	output logic [QW-1:0]     cos_q
);

	logic [DEN_W-1:0] den_s1;
	logic [DEN_W-1:0] num_s1;
	dv_pipe_t         stg_s [DIV_STAGES];
	dv_pipe_t         head;

	always_ff @(posedge clk) begin
		den_s1 <= DEN_W'(na) * DEN_W'(nb);
		num_s1 <= num;
	end

	// quotient of (num << 16) / den; top bits start the remainder, the rest shift in
	assign head = '{
		acc: '{rem: {2'b00, num_s1[DEN_W-1:2]}, q: '0},
		low: {num_s1[1:0], {COS_FRAC{1'b0}}},
		den: den_s1
	};

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		dv_pipe_t prev;
		dv_pipe_t nxt;

		if (k == 0) begin : g_first
			assign prev = head;
		end else begin : g_next
			assign prev = stg_s[k-1];
		end

		always_comb begin
			nxt = prev;
			for (int j = 0; j < DIV_PER; j++) begin
				nxt.acc = dv_step(nxt.acc, nxt.den, nxt.low[QW-1]);
				nxt.low = {nxt.low[QW-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk) begin
			stg_s[k] <= nxt;
		end
	end

	assign cos_q = stg_s[DIV_STAGES-1].acc.q;

endmodule

[rtl/accel_pose_classifier_core.sv]
// Accelerometer pose classifier top level: config registers, pipeline control, pose pick.
`timescale 1ns / 1ps

// Takes one sample per clock (busy stays low) and shows its pose on pose with done high
// for one cycle; items leave in order. A sample passes the input registers, the dot
// product, the square root, which resolves two root bits per stage (16 stages), the
// norm product and the cosine divider, which resolves two quotient bits per stage
// (9 stages), then the output registers. The results cannot be held off, so the
// pipeline advances every cycle. Configuration may be written only with no sample in
// flight; a new sample may follow the write at once.

module accel_pose_classifier_core
	import apc_pkg::*;
#(
	parameter int SAMPLE_WIDTH = 16,
	parameter int FRAC_BITS    = 12
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [REG_IDX_W-1:0]      cfg_idx,
	input  logic [3*SAMPLE_WIDTH-1:0] cfg_wdata,
	input  logic                      start,
	input  logic [SAMPLE_WIDTH-1:0]   accel_x,
	input  logic [SAMPLE_WIDTH-1:0]   accel_y,
	input  logic [SAMPLE_WIDTH-1:0]   accel_z,
	output logic                      busy,
	output logic                      done,
	output logic [2:0]                pose
);

	localparam int SW      = SAMPLE_WIDTH;
	localparam int TH_SIDE = ((7 << FRAC_BITS) + 5) / 10;
	localparam int TH_FLAT = ((17 << FRAC_BITS) + 10) / 20;
	localparam int TH_MIN  = ((1 << FRAC_BITS) + 5) / 10;
	localparam logic [RAD_W-1:0] TMIN2 = RAD_W'(TH_MIN) * RAD_W'(TH_MIN);
	localparam int GSH     = RAD_W - 2 * SW;
	localparam int CTL_DLY = SQ_STAGES + 1 + DIV_STAGES;

	logic                calibrated_q;
	logic [3*SW-1:0]     refs_q [NUM_REFS];

	logic                vld_s1;
	logic signed [SW-1:0] x_s1, y_s1, z_s1;
	logic                vld_s2, vld_s3;
	pose_t               fpose_s2, fpose_s3;
	pose_t               fast_pose;

	logic signed [31:0]  sx, sy, sz;
	logic signed [SW-1:0] s_vec [3];
	logic signed [SW-1:0] r_vec [NUM_REFS][3];

	logic signed [2*SW:0] ms_s3;
	logic signed [2*SW:0] mr_s3 [NUM_REFS];
	logic signed [2*SW:0] d_s3 [NUM_REFS];

	logic                s_weak;
	ctl_t                ctl_in;
	ctl_t                ctl_d [CTL_DLY];
	logic [RAD_W-1:0]    rad_s;
	logic [RAD_W-1:0]    rad_r [NUM_REFS];
	logic [DEN_W-1:0]    num_c [NUM_REFS];
	logic [DEN_W-1:0]    num_d [NUM_REFS][SQ_STAGES];
	logic [ROOT_W-1:0]   na;
	logic [ROOT_W-1:0]   nb [NUM_REFS];
	logic [QW-1:0]       cos_q [NUM_REFS];

	ctl_t                ctl_out;
	logic [QW-1:0]       best_val;
	logic [1:0]          best_idx;
	pose_t               match_pose;

	assign busy = 1'b0;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calibrated_q <= 1'b0;
			for (int i = 0; i < NUM_REFS; i++) begin
				refs_q[i] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_CALIBRATED:  calibrated_q <= cfg_wdata[0];
				REG_REF_UPRIGHT: refs_q[0] <= cfg_wdata;
				REG_REF_LEFT:    refs_q[1] <= cfg_wdata;
				REG_REF_RIGHT:   refs_q[2] <= cfg_wdata;
				REG_REF_FLAT:    refs_q[3] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		x_s1     <= accel_x;
		y_s1     <= accel_y;
		z_s1     <= accel_z;
		fpose_s2 <= fast_pose;
		fpose_s3 <= fpose_s2;
	end

	// fixed threshold rules
	assign sx = 32'(x_s1);
	assign sy = 32'(y_s1);
	assign sz = 32'(z_s1);

	always_comb begin
		if (sz > -TH_SIDE && sz < TH_SIDE) begin
			priority if (sx < -TH_SIDE) fast_pose = POSE_LEFT;
			else if (sy > TH_SIDE)      fast_pose = POSE_RIGHT;
			else if (sy < -TH_SIDE)     fast_pose = POSE_UPRIGHT;
			else                        fast_pose = POSE_UNKNOWN;
		end else if (sz < -TH_FLAT) begin
			fast_pose = POSE_FLAT;
		end else begin
			fast_pose = POSE_UNKNOWN;
		end
	end

	// dot products and squared norms
	assign s_vec[0] = x_s1;
	assign s_vec[1] = y_s1;
	assign s_vec[2] = z_s1;

	apc_dot3 #(.W(SW)) u_ms (.clk(clk), .a(s_vec), .b(s_vec), .dot(ms_s3));

	for (genvar i = 0; i < NUM_REFS; i++) begin : g_ref
		for (genvar c = 0; c < 3; c++) begin : g_comp
			assign r_vec[i][c] = $signed(refs_q[i][c*SW +: SW]);
		end

		apc_dot3 #(.W(SW)) u_mr (.clk(clk), .a(r_vec[i]), .b(r_vec[i]), .dot(mr_s3[i]));
		apc_dot3 #(.W(SW)) u_dot (.clk(clk), .a(s_vec), .b(r_vec[i]), .dot(d_s3[i]));

		assign rad_r[i] = RAD_W'(mr_s3[i][2*SW-1:0]) << GSH;
		assign num_c[i] = DEN_W'(d_s3[i][2*SW-1:0]) << GSH;
		// a weak pair or a non-positive cosine can never reach the match floor
		assign ctl_in.use_ref[i] = !s_weak && (RAD_W'(mr_s3[i][2*SW-1:0]) >= TMIN2)
			&& (d_s3[i] > 0);

		apc_isqrt u_nb (.clk(clk), .rad(rad_r[i]), .root(nb[i]));

		apc_cosdiv u_div (
			.clk  (clk),
			.num  (num_d[i][SQ_STAGES-1]),
			.na   (na),
			.nb   (nb[i]),
			.cos_q(cos_q[i])
		);
	end

	assign s_weak       = RAD_W'(ms_s3[2*SW-1:0]) < TMIN2;
	assign rad_s        = RAD_W'(ms_s3[2*SW-1:0]) << GSH;
	assign ctl_in.vld   = vld_s3;
	assign ctl_in.fpose = fpose_s3;

	apc_isqrt u_na (.clk(clk), .rad(rad_s), .root(na));

	// hold numerators while the norms resolve
	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_REFS; i++) begin
			num_d[i][0] <= num_c[i];
			for (int k = 1; k < SQ_STAGES; k++) begin
				num_d[i][k] <= num_d[i][k-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < CTL_DLY; k++) begin
				ctl_d[k] <= '{vld: 1'b0, fpose: POSE_UNKNOWN, use_ref: '0};
			end
		end else begin
			ctl_d[0] <= ctl_in;
			for (int k = 1; k < CTL_DLY; k++) begin
				ctl_d[k] <= ctl_d[k-1];
			end
		end
	end

	assign ctl_out = ctl_d[CTL_DLY-1];

	// first strictly largest cosine wins
	always_comb begin
		logic [QW-1:0] val;
		best_val = '0;
		best_idx = '0;
		for (int i = 0; i < NUM_REFS; i++) begin
			val = ctl_out.use_ref[i] ? cos_q[i] : '0;
			if (i == 0 || val > best_val) begin
				best_val = val;
				best_idx = 2'(i);
			end
		end
		match_pose = (best_val >= COS_MIN) ? pose_t'(3'(best_idx) + 3'd1) : POSE_UNKNOWN;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctl_out.vld;
		end
	end

	always_ff @(posedge clk) begin
		pose <= calibrated_q ? match_pose : ctl_out.fpose;
	end

endmodule

[sim/apc_checker.sv]
// Pose checker: watches samples, register writes and poses, predicts and compares.
`timescale 1ns / 1ps

module apc_checker
	import apc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [47:0] cfg_wdata,
	input  logic        start,
	input  logic        busy,
	input  logic [15:0] accel_x,
	input  logic [15:0] accel_y,
	input  logic [15:0] accel_z,
	input  logic        done,
	input  logic [2:0]  pose,
	output int          fail_count,
	output int          poses_pending
);

	localparam longint SIDE_TH = 2867;
	localparam longint FLAT_TH = 3482;
	localparam longint WEAK_SQ = 410 * 410;

	logic        cal_mode;
	logic [47:0] ref_vec [NUM_REFS];
	pose_t       pose_q[$];

	task automatic report(input string what);
		$display("MISMATCH at %0t: %s", $realtime, what);
		fail_count++;
	endtask

	function automatic longint unsigned root64(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic pose_t classify(logic signed [15:0] sx, logic signed [15:0] sy,
			logic signed [15:0] sz);
		longint s [3], v [3];
		longint d, best_cos, c;
		longint unsigned ms, mr, na, nb, den, num, q, rem;
		int best;
		s[0] = sx; s[1] = sy; s[2] = sz;
		if (!cal_mode) begin
			if (s[2] > -SIDE_TH && s[2] < SIDE_TH) begin
				if (s[0] < -SIDE_TH) return POSE_LEFT;
				if (s[1] > SIDE_TH) return POSE_RIGHT;
				if (s[1] < -SIDE_TH) return POSE_UPRIGHT;
				return POSE_UNKNOWN;
			end
			return (s[2] < -FLAT_TH) ? POSE_FLAT : POSE_UNKNOWN;
		end
		ms = s[0]*s[0] + s[1]*s[1] + s[2]*s[2];
		if (ms < WEAK_SQ) return POSE_UNKNOWN;
		best = -1;
		best_cos = 0;
		for (int i = 0; i < NUM_REFS; i++) begin
			for (int k = 0; k < 3; k++) v[k] = longint'($signed(ref_vec[i][16*k +: 16]));
			mr = v[0]*v[0] + v[1]*v[1] + v[2]*v[2];
			if (mr < WEAK_SQ) continue;
			d = s[0]*v[0] + s[1]*v[1] + s[2]*v[2];
			na = root64(ms << 32);
			nb = root64(mr << 32);
			den = na * nb;
			num = (d < 0 ? -d : d);
			num = num << 32;
			q = num / den;
			rem = num % den;
			for (int j = 0; j < 16; j++) begin
				q <<= 1;
				if (rem >= den - rem) begin
					rem = rem - (den - rem);
					q |= 1;
				end else begin
					rem += rem;
				end
			end
			c = (d < 0) ? -longint'(q) : longint'(q);
			if (best < 0 || c > best_cos) begin
				best_cos = c;
				best = i;
			end
		end
		if (best < 0 || best_cos < 32768) return POSE_UNKNOWN;
		return pose_t'(best + 1);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_mode <= 1'b0;
			for (int i = 0; i < NUM_REFS; i++) ref_vec[i] <= '0;
			pose_q.delete();
			fail_count <= 0;
			poses_pending <= 0;
		end else begin
			if (start && !busy) pose_q.push_back(classify(accel_x, accel_y, accel_z));
			if (cfg_we) begin
				if (cfg_idx == REG_CALIBRATED) cal_mode <= cfg_wdata[0];
				else if (cfg_idx <= REG_REF_FLAT) ref_vec[cfg_idx - 1] <= cfg_wdata;
			end
			if (done) begin
				if (pose_q.size() == 0) report("pose with no sample waiting");
				else if (pose !== pose_q[0]) begin
					report($sformatf("pose %0d, expected %0d", pose, pose_q[0]));
					void'(pose_q.pop_front());
				end else begin
					void'(pose_q.pop_front());
				end
			end
			poses_pending <= pose_q.size();
		end
	end

endmodule

[sim/tb_accel_pose_classifier_core.sv]
// Testbench top: drives samples and register writes into the pose classifier, gives the verdict.
`timescale 1ns / 1ps

module tb_accel_pose_classifier_core
	import apc_pkg::*;
();

	localparam int LATENCY = 30;
	localparam int WD_LIMIT = 2000;

	logic        clk, arst_n, cfg_we, start, busy, done;
	logic [2:0]  cfg_idx, pose;
	logic [47:0] cfg_wdata;
	logic [15:0] accel_x, accel_y, accel_z;
	int          fail_count, poses_pending, idle_cycles, sample_total;

	accel_pose_classifier_core dut (.*);

	apc_checker chk (.*);

	always begin
		clk = 1'b0; #2;
		clk = 1'b1; #2;
	end

	always @(posedge clk) begin
		if ((start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WD_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic logic [47:0] pack_vec(int x, int y, int z);
		return {16'(z), 16'(y), 16'(x)};
	endfunction

	function automatic logic [15:0] rand_axis();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'($urandom_range(0, 900)) - 16'd450;
			3: return 16'($urandom_range(2700, 3700));
			4: return -16'($urandom_range(2700, 3700));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z, bit gaps);
		if (gaps && $urandom_range(0, 5) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		start <= 1'b1;
		accel_x <= x;
		accel_y <= y;
		accel_z <= z;
		@(posedge clk);
		while (busy) @(posedge clk);
		sample_total++;
	endtask

	task automatic write_reg(logic [2:0] idx, logic [47:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (poses_pending != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic random_refs();
		for (int i = 1; i <= NUM_REFS; i++) begin
			if ($urandom_range(0, 5) == 0) write_reg(3'(i), 48'({$urandom, $urandom}));
			else write_reg(3'(i), pack_vec($urandom_range(0, 8000) - 4000,
				$urandom_range(0, 8000) - 4000, $urandom_range(0, 8000) - 4000));
		end
	endtask

	task automatic random_phase(int count, bit gaps);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_sample(16'($urandom_range(0, 400)) - 16'd200,
					16'($urandom_range(0, 400)) - 16'd200, 16'($urandom_range(0, 60)), gaps);
			else send_sample(rand_axis(), rand_axis(), rand_axis(), gaps);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_CALIBRATED;
		cfg_wdata = '0;
		start = 1'b0;
		accel_x = '0;
		accel_y = '0;
		accel_z = '0;
		idle_cycles = 0;
		sample_total = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fixed threshold rules, boundaries on each side
		send_sample(16'd0, 16'd0, 16'd0, 0);
		send_sample(-16'd2868, 16'd0, 16'd0, 0);
		send_sample(-16'd2867, 16'd0, 16'd0, 0);
		send_sample(16'd0, 16'd2868, 16'd2866, 0);
		send_sample(16'd0, 16'd2867, -16'd2866, 0);
		send_sample(16'd0, -16'd2868, 16'd0, 0);
		send_sample(-16'd4000, 16'd4000, 16'd0, 0);
		send_sample(16'd0, 16'd0, -16'd3483, 0);
		send_sample(16'd0, 16'd0, -16'd3482, 0);
		send_sample(16'd0, 16'd0, 16'd2867, 0);
		send_sample(16'h8000, 16'h8000, 16'h8000, 0);
		send_sample(16'h7fff, 16'h7fff, 16'h7fff, 0);
		drain();

		// references along the axes, one left weak at reset value
		write_reg(REG_CALIBRATED, 48'd1);
		write_reg(REG_REF_UPRIGHT, pack_vec(0, -4096, 0));
		write_reg(REG_REF_LEFT, pack_vec(-4096, 0, 0));
		write_reg(REG_REF_RIGHT, pack_vec(0, 4096, 0));
		send_sample(16'd0, -16'd4096, 16'd0, 0);
		send_sample(-16'd4096, 16'd0, 16'd0, 0);
		send_sample(16'd0, 16'd0, -16'd4096, 0);
		send_sample(16'd200, 16'd200, 16'd200, 0);
		send_sample(16'd0, 16'd409, 16'd0, 0);
		send_sample(16'd0, 16'd410, 16'd0, 0);
		send_sample(-16'd4096, -16'd4096, 16'd0, 0);
		send_sample(16'h8000, 16'h8000, 16'h8000, 0);
		drain();
		// duplicate references: first one wins on a tie
		write_reg(REG_REF_FLAT, pack_vec(0, -4096, 0));
		write_reg(REG_REF_LEFT, 48'hffff_ffff_ffff);
		send_sample(16'd0, -16'd4096, 16'd0, 0);
		send_sample(16'h7fff, 16'h7fff, 16'h7fff, 0);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			write_reg(REG_CALIBRATED, 48'(ph % 4 != 0) | (48'($urandom) << 1));
			random_refs();
			random_phase(60, ph < 7);
			drain();
		end
		write_reg(REG_REF_FLAT, {16'h8000, 16'h8000, 16'h8000});
		write_reg(REG_REF_UPRIGHT, {16'h7fff, 16'h7fff, 16'h7fff});
		write_reg(3'd7, 48'd0);
		random_phase(100, 0);
		drain();
		repeat (LATENCY + 5) @(posedge clk);

		if (fail_count == 0 && poses_pending == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
